FILE: design/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// shared types and constants of the thresholded sobel edge detector
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [1:0] REG_EUCLID_MODE  = 2'd3;

  localparam logic [11:0] RST_LINE_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [10:0] RST_THRESHOLD    = 11'd150;
  localparam logic        RST_EUCLID_MODE  = 1'b1;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
  } geom_t;

  typedef struct packed {
    logic [10:0] thresh;
    logic        euclid;
  } mag_cfg_t;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [11:0]        row;
    logic [10:0]        col;
    logic               last;
  } grad_t;

endpackage

FILE: design/sed_ram.sv
// ----------------------------------------------------------------------------
// sed_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sed_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sed_front.sv
// ----------------------------------------------------------------------------
// sed_front
// position counters, line stores, 3x3 window and sobel gradients
// ----------------------------------------------------------------------------
module sed_front #(
  parameter int unsigned MAX_LINE_WIDTH = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sed_pkg::geom_t geom_i,
  input  logic           accept_i,
  input  logic [7:0]     pixel_i,
  input  logic           frame_start_i,
  output logic           busy_o,
  output logic           push_o,
  output sed_pkg::grad_t push_data_o
);
  import sed_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
  typedef logic [AW-1:0] addr_t;

  logic [11:0] col_q, col_d, row_q, row_d;
  logic [11:0] col_use, row_use;
  addr_t       addr_now;

  logic        s1_valid_q;
  logic [7:0]  s1_px_q;
  logic [10:0] s1_col_q;
  logic [11:0] s1_row_q;
  logic        s1_int_q, s1_last_q, s1_hz_q;
  addr_t       s1_addr_q;
  logic [7:0]  byp_u_q, byp_m_q;

  logic [15:0] rd_data;
  logic [7:0]  ru, rm;
  logic [7:0]  win_q [6];

  logic signed [10:0] gx, gy;
  logic signed [10:0] s_ru, s_rm, s_rl, s_cu, s_cl, s_lu, s_lm, s_ll;

  // position of the incoming pixel
  always_comb begin
    col_use  = frame_start_i ? 12'd0 : col_q;
    row_use  = frame_start_i ? 12'd0 : row_q;
    addr_now = addr_t'(col_use);
    col_d    = col_q;
    row_d    = row_q;
    if (accept_i) begin
      if ({1'b0, col_use} + 13'd1 >= {1'b0, geom_i.width}) begin
        col_d = 12'd0;
        if ({1'b0, row_use} + 13'd1 >= {1'b0, geom_i.height}) begin
          row_d = 12'd0;
        end else begin
          row_d = row_use + 12'd1;
        end
      end else begin
        col_d = col_use + 12'd1;
        row_d = row_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_use[10:0];
      s1_row_q  <= row_use;
      s1_addr_q <= addr_now;
      s1_int_q  <= (row_use >= 12'd2) && (col_use >= 12'd2);
      s1_last_q <= (row_use == geom_i.height - 12'd1) && (col_use == geom_i.width - 12'd1);
      s1_hz_q   <= s1_valid_q && (s1_addr_q == addr_now);
    end
    if (s1_valid_q) begin
      byp_u_q <= rm;
      byp_m_q <= s1_px_q;
    end
  end

  sed_ram #(
    .WIDTH (16),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({rm, s1_px_q}),
    .re_i    (accept_i),
    .raddr_i (addr_now),
    .rdata_o (rd_data)
  );

  // forward the write of the previous pixel when it hit the same column
  assign ru = s1_hz_q ? byp_u_q : rd_data[15:8];
  assign rm = s1_hz_q ? byp_m_q : rd_data[7:0];

  // window: 0..2 column col-1 (top, mid, bottom), 3..5 column col-2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= ru;
      win_q[1] <= rm;
      win_q[2] <= s1_px_q;
    end
  end

  always_comb begin
    s_ru = signed'({3'b000, ru});
    s_rm = signed'({3'b000, rm});
    s_rl = signed'({3'b000, s1_px_q});
    s_cu = signed'({3'b000, win_q[0]});
    s_cl = signed'({3'b000, win_q[2]});
    s_lu = signed'({3'b000, win_q[3]});
    s_lm = signed'({3'b000, win_q[4]});
    s_ll = signed'({3'b000, win_q[5]});
    gx   = (s_ru - s_lu) + ((s_rm - s_lm) <<< 1) + (s_rl - s_ll);
    gy   = (s_ll + (s_cl <<< 1) + s_rl) - (s_lu + (s_cu <<< 1) + s_ru);
  end

  assign push_o           = s1_valid_q && s1_int_q;
  assign push_data_o.gx   = gx;
  assign push_data_o.gy   = gy;
  assign push_data_o.row  = s1_row_q - 12'd1;
  assign push_data_o.col  = s1_col_q - 11'd1;
  assign push_data_o.last = s1_last_q;
  assign busy_o           = s1_valid_q;

endmodule

FILE: design/sed_queue.sv
// ----------------------------------------------------------------------------
// sed_queue
// short fifo of gradient records between front and back
// ----------------------------------------------------------------------------
module sed_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  sed_pkg::grad_t            push_data_i,
  input  logic                      pop_i,
  output logic                      not_empty_o,
  output sed_pkg::grad_t            pop_data_o,
  output logic [sed_pkg::QCNT_W-1:0] count_o
);
  import sed_pkg::*;

  grad_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == QCNT_W'(QDEPTH)) |-> !push_i)
    else $error("push into full queue");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

FILE: design/sed_back.sv
// ----------------------------------------------------------------------------
// sed_back
// gradient magnitude, threshold test and output register
// ----------------------------------------------------------------------------
module sed_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sed_pkg::mag_cfg_t mag_cfg_i,
  input  logic              q_not_empty_i,
  input  sed_pkg::grad_t    q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        edge_pixel_o,
  output logic [11:0]       out_row_o,
  output logic [10:0]       out_col_o,
  output logic              frame_last_o
);
  import sed_pkg::*;

  logic        en;
  logic        b1_valid_q, b2_valid_q, out_valid_q;
  logic [9:0]  b1_ax_q, b1_ay_q;
  logic [11:0] b1_row_q, b2_row_q, out_row_q;
  logic [10:0] b1_col_q, b2_col_q, out_col_q;
  logic        b1_last_q, b2_last_q, out_last_q;
  logic [19:0] b2_sqx_q, b2_sqy_q;
  logic [10:0] b2_l1_q;
  logic [21:0] b2_tt_q;
  logic [7:0]  out_pix_q;
  logic [9:0]  ax_full, ay_full;
  logic [21:0] l2_sum;
  logic        is_edge;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_not_empty_i;

  // gradient magnitudes stay below 1024
  assign ax_full = q_data_i.gx[10] ? 10'(-q_data_i.gx) : 10'(q_data_i.gx);
  assign ay_full = q_data_i.gy[10] ? 10'(-q_data_i.gy) : 10'(q_data_i.gy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= q_not_empty_i;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  assign l2_sum  = {2'b00, b2_sqx_q} + {2'b00, b2_sqy_q};
  assign is_edge = mag_cfg_i.euclid ? (l2_sum > b2_tt_q) : (b2_l1_q > mag_cfg_i.thresh);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_ax_q    <= ax_full;
      b1_ay_q    <= ay_full;
      b1_row_q   <= q_data_i.row;
      b1_col_q   <= q_data_i.col;
      b1_last_q  <= q_data_i.last;
      b2_sqx_q   <= 20'(b1_ax_q) * 20'(b1_ax_q);
      b2_sqy_q   <= 20'(b1_ay_q) * 20'(b1_ay_q);
      b2_l1_q    <= {1'b0, b1_ax_q} + {1'b0, b1_ay_q};
      b2_tt_q    <= 22'(mag_cfg_i.thresh) * 22'(mag_cfg_i.thresh);
      b2_row_q   <= b1_row_q;
      b2_col_q   <= b1_col_q;
      b2_last_q  <= b1_last_q;
      out_pix_q  <= is_edge ? EDGE_ON : EDGE_OFF;
      out_row_q  <= b2_row_q;
      out_col_q  <= b2_col_q;
      out_last_q <= b2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_pixel_o = out_pix_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

endmodule

FILE: design/sobel_edge_threshold_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold_unit
// thresholded 3x3 sobel edge detector on a raster stream of 8-bit pixels
//
// channel   dir  tdata                               tuser        tlast
// s_axis    in   [7:0] pixel                         frame_start  -
// m_axis    out  [7:0] edge_pixel [19:8] out_row     -            frame_last
//                [30:20] out_col [31] zero
// cfg       in   index 0 width, 1 height, 2 threshold, 3 euclid mode
//
// one pixel per clock sustained while m_axis accepts results; a pixel's result passes
// through the front stage, the queue and the back stages b1, b2 and out
// line stores live in one ram, read at accept and written in the next cycle
// reset clears counters, window, queue pointers, valids and config, no ram clearing pass
// s_axis_tready drops when the queue count plus the pixel in flight reach the depth of four
// m_axis stalls hold the back pipeline, the front keeps going into the queue
module sobel_edge_threshold_unit #(
  parameter int unsigned MAX_LINE_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] edge_pixel, [19:8] out_row, [30:20] out_col
  output logic        m_axis_tlast
);
  import sed_pkg::*;

  localparam int unsigned MaxW = (MAX_LINE_WIDTH > 4095) ? 4095 : MAX_LINE_WIDTH;

  logic [11:0] line_width_q, frame_height_q;
  logic [10:0] thresh_q;
  logic        euclid_q;

  geom_t       geom;
  mag_cfg_t    mag_cfg;
  logic        accept, front_busy, push, pop, q_not_empty;
  grad_t       push_data, pop_data;
  logic [QCNT_W-1:0] q_count;
  logic [7:0]  edge_pixel;
  logic [11:0] out_row;
  logic [10:0] out_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= RST_LINE_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      thresh_q       <= RST_THRESHOLD;
      euclid_q       <= RST_EUCLID_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_THRESHOLD:    thresh_q       <= cfg_data_i[10:0];
        REG_EUCLID_MODE:  euclid_q       <= cfg_data_i[0];
        default:          euclid_q       <= euclid_q;
      endcase
    end
  end

  always_comb begin
    geom.width = line_width_q;
    if (line_width_q < 12'd3) begin
      geom.width = 12'd3;
    end else if (line_width_q > 12'(MaxW)) begin
      geom.width = 12'(MaxW);
    end
    geom.height    = (frame_height_q < 12'd3) ? 12'd3 : frame_height_q;
    mag_cfg.thresh = thresh_q;
    mag_cfg.euclid = euclid_q;
  end

  assign s_axis_tready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, front_busy})
                         < (QCNT_W + 1)'(QDEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  sed_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .accept_i      (accept),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .busy_o        (front_busy),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  sed_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (pop_data),
    .count_o     (q_count)
  );

  sed_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mag_cfg_i     (mag_cfg),
    .q_not_empty_i (q_not_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .edge_pixel_o  (edge_pixel),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .frame_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_col, out_row, edge_pixel};

endmodule

FILE: test/tb_sobel_edge_threshold_unit.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold_unit
// self-checking bench for the thresholded 3x3 sobel edge detector: streams
// raster frames of many shapes and settings, predicts each interior edge
// result with a cycle-free model of the line stores, window and counters,
// and checks every output transaction in order under random stalls
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned RAND_PIXELS = 1200;

  typedef enum int unsigned {PX_NOISE, PX_BINARY, PX_FLAT} px_style_e;

  typedef struct packed {
    logic [7:0]  px;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } edge_res_t;

  class sobel_edge_tracker;
    bit [7:0]     upper_line [MAX_W];
    bit [7:0]     middle_line [MAX_W];
    bit [7:0]     win [6];
    int unsigned  col = 0;
    int unsigned  row = 0;
    logic [11:0]  width_reg = RST_LINE_WIDTH;
    logic [11:0]  height_reg = RST_FRAME_HEIGHT;
    logic [10:0]  thresh = RST_THRESHOLD;
    logic         euclid = RST_EUCLID_MODE;
    edge_res_t    due [$];
    int unsigned  errors = 0;

    function int unsigned frame_w();
      return width_reg < 3 ? 3 : (width_reg > MAX_W ? MAX_W : width_reg);
    endfunction

    function int unsigned frame_h();
      return height_reg < 3 ? 3 : height_reg;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        REG_LINE_WIDTH:   width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        REG_THRESHOLD:    thresh = data[10:0];
        REG_EUCLID_MODE:  euclid = data[0];
        default: ;
      endcase
    endfunction

    function void add_pixel(logic [7:0] px, logic fs);
      int unsigned w, h, idx, ax, ay, t;
      int ru, rm, rl, cu, cl, lu, lm, ll, gx, gy;
      bit hit;
      edge_res_t r;
      w = frame_w();
      h = frame_h();
      t = thresh;
      if (fs) begin
        col = 0;
        row = 0;
      end
      idx = col % MAX_W;
      ru = upper_line[idx];
      rm = middle_line[idx];
      rl = px;
      cu = win[0];
      cl = win[2];
      lu = win[3];
      lm = win[4];
      ll = win[5];
      if (row >= 2 && col >= 2) begin
        gx = (ru - lu) + 2 * (rm - lm) + (rl - ll);
        gy = (ll + 2 * cl + rl) - (lu + 2 * cu + ru);
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (euclid) hit = ax * ax + ay * ay > t * t;
        else hit = ax + ay > t;
        r.px = hit ? EDGE_ON : EDGE_OFF;
        r.row = 12'(row - 1);
        r.col = 11'(col - 1);
        r.last = (row == h - 1) && (col == w - 1);
        due.push_back(r);
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = 8'(ru);
      win[1] = 8'(rm);
      win[2] = px;
      upper_line[idx] = 8'(rm);
      middle_line[idx] = px;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_edge(logic [7:0] px, logic [11:0] r, logic [10:0] c, logic lst);
      edge_res_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result px=%0d row=%0d col=%0d last=%0b", px, r, c, lst));
        return;
      end
      want = due.pop_front();
      if (want.px !== px || want.row !== r || want.col !== c || want.last !== lst)
        report($sformatf("expected px=%0d row=%0d col=%0d last=%0b, got px=%0d row=%0d col=%0d last=%0b",
                         want.px, want.row, want.col, want.last, px, r, c, lst));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_LINE_WIDTH;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] pixel
  logic        s_axis_tuser = 1'b0; // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] edge_pixel, [19:8] out_row, [30:20] out_col
  logic        m_axis_tlast;
  bit          calm = 1'b0;

  sobel_edge_tracker edges = new();

  sobel_edge_threshold_unit #(
    .MAX_LINE_WIDTH(MAX_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // output side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      edges.check_edge(m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[30:20],
                       m_axis_tlast);
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] pick_px(px_style_e sty, logic [7:0] base);
    int unsigned v;
    case (sty)
      PX_NOISE:  return 8'($urandom_range(0, 255));
      PX_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: begin
        v = base + $urandom_range(0, 3);
        return v > 255 ? 8'd255 : 8'(v);
      end
    endcase
  endfunction

  task automatic send_px(logic [7:0] px, logic fs);
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    edges.add_pixel(px, fs);
  endtask

  task automatic run_frame(bit fs_first, px_style_e sty, int unsigned count);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int unsigned n = 0; n < count; n++)
      send_px(pick_px(sty, base), fs_first && n == 0);
  endtask

  // 3x3 frame whose columns hold a, b and c
  task automatic column_frame(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit fs);
    for (int r = 0; r < 3; r++) begin
      send_px(a, fs && r == 0);
      send_px(b, 1'b0);
      send_px(c, 1'b0);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (edges.due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [11:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    edges.set_reg(idx, data);
  endtask

  task automatic configure(input logic [11:0] wv, hv, tv, mv, input bit full);
    cfg_write(REG_LINE_WIDTH, wv);
    cfg_write(REG_FRAME_HEIGHT, hv);
    if (full) begin
      cfg_write(REG_THRESHOLD, tv);
      cfg_write(REG_EUCLID_MODE, mv);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned rand_px, nfr, area, cnt;
    bit chop, cut;
    logic [11:0] wv, hv, tv;
    px_style_e sty;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // undersized geometry, threshold and mode from reset
    configure(12'd0, 12'd2, '0, '0, 1'b0);
    column_frame(8'd0, 8'd128, 8'd255, 1'b1);
    column_frame(8'd100, 8'd100, 8'd100, 1'b0);

    // oversized width, top threshold, no idling on either side
    wait_idle();
    calm = 1'b1;
    configure(12'd4095, 12'd3, 12'hFFF, 12'hFFE, 1'b1);
    run_frame(1'b1, PX_BINARY, 64);
    wait_idle();
    calm = 1'b0;

    // tallest frame, zero threshold
    configure(12'd3, 12'd4095, 12'd0, 12'd1, 1'b1);
    run_frame(1'b1, PX_FLAT, edges.frame_w() * 40);

    // magnitude equal to threshold, then just above it
    wait_idle();
    configure(12'd3, 12'd3, 12'd4, 12'd1, 1'b1);
    column_frame(8'd0, 8'd0, 8'd1, 1'b1);
    column_frame(8'd7, 8'd7, 8'd7, 1'b0);
    wait_idle();
    configure(12'd3, 12'd3, 12'd3, 12'd0, 1'b1);
    column_frame(8'd0, 8'd0, 8'd1, 1'b1);

    // geometry shrunk under the counters mid-frame
    wait_idle();
    configure(12'd6, 12'd5, 12'd60, 12'd0, 1'b1);
    run_frame(1'b1, PX_NOISE, 16);
    wait_idle();
    configure(12'd4, 12'd0, '0, '0, 1'b0);
    run_frame(1'b0, PX_NOISE, 13);

    rand_px = 0;
    while (rand_px < RAND_PIXELS) begin
      wait_idle();
      wv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 14));
      hv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8));
      case ($urandom_range(0, 7))
        0: tv = 12'd0;
        1: tv = 12'd2047;
        default: tv = 12'($urandom_range(0, 599));
      endcase
      tv[11] = 1'($urandom_range(0, 1));
      configure(wv, hv, tv, 12'($urandom_range(0, 4095)), 1'b1);
      area = edges.frame_w() * edges.frame_h();
      nfr = $urandom_range(1, 3);
      cut = 1'b0;
      for (int unsigned f = 0; f < nfr; f++) begin
        chop = (f + 1 < nfr) && ($urandom_range(0, 7) == 0);
        cnt = chop ? $urandom_range(1, area - 1) : area;
        sty = px_style_e'($urandom_range(0, 2));
        run_frame(f == 0 || cut || $urandom_range(0, 1), sty, cnt);
        cut = chop;
        rand_px += cnt;
      end
      if ($urandom_range(0, 4) == 0) begin
        cnt = $urandom_range(1, area - 1);
        run_frame(1'b1, sty, cnt);
        wait_idle();
        configure(12'($urandom_range(0, edges.frame_w())),
                  12'($urandom_range(0, edges.frame_h() + 3)), '0, '0, 1'b0);
        run_frame(1'b0, sty, 40);
        rand_px += cnt + 40;
      end
    end

    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < 100000 && edges.due.size() != 0; n++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (edges.due.size() != 0)
      edges.report($sformatf("%0d edge results never arrived", edges.due.size()));
    if (edges.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
